>>> hdl/ubdc_pkg.sv
// Shared types, widths and constants of the UART baud divisor calculator.
package ubdc_pkg;

	localparam int CLK_W    = 28;
	localparam int BAUD_W   = 24;
	localparam int CFG_IDX_W = 2;
	localparam int NUM_W    = 33;
	localparam int DVSR_W   = 26;
	localparam int MANT_W   = 12;
	localparam int FRAC_W   = 4;
	localparam int WORD_W   = 16;
	localparam int STAT_W   = 2;
	localparam int DIVL_W   = 19;
	localparam int REM100_W = 7;

	localparam logic [CFG_IDX_W-1:0] REG_SLOW_CLK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FAST_CLK = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OVER8    = 2'd2;

	localparam logic [CLK_W-1:0] CLK_RESET = 28'd16000000;

	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_BAUD_ZERO = 2'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE     = 2'd2;

	localparam logic [MANT_W-1:0] MANT_MAX  = 12'd4095;
	localparam logic [DIVL_W-1:0] DIV_LIMIT = 19'd409600;
	localparam logic [19:0]       RECIP100  = 20'd671089;
	localparam logic [11:0]       RECIP100_SMALL = 12'd2622;
	localparam logic [10:0]       ROUND_HALF = 11'd50;
	localparam logic [DIVL_W-1:0] HUNDRED   = 19'd100;
	localparam logic [FRAC_W-1:0] FMASK8    = 4'h7;
	localparam logic [FRAC_W-1:0] FMASK16   = 4'hF;

	typedef struct packed {
		logic [DVSR_W-1:0] rem;
		logic [NUM_W-1:0]  dq;
		logic [DVSR_W-1:0] dvsr;
		logic              zero;
		logic              by8;
	} cell_t;

endpackage

>>> hdl/uart_baud_divisor_calc_top.sv
// Top level of the UART fractional baud divisor calculator.
// Each item (baud rate and clock choice) yields one result: mantissa, fraction, packed
// divisor word and status. The block takes one item per clock cycle while the output side
// does not stall and returns each result through its registered stages: one input
// stage, a chain of 33 division cells that each produce one quotient bit of
// 25*clock / (2 or 4 * baud), and three stages that split the divider into mantissa and
// rounded fraction. Each stage holds an item independently, so idle stages fill even while
// a result waits at the output. Configuration registers take effect on the next item.
module uart_baud_divisor_calc_top
	import ubdc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CLK_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [BAUD_W-1:0]    baud_rate,
	input  logic                 use_fast_clock,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [MANT_W-1:0]    mantissa,
	output logic [FRAC_W-1:0]    fraction,
	output logic [WORD_W-1:0]    divisor_word,
	output logic [STAT_W-1:0]    status
);

	logic [CLK_W-1:0] slow_clk_q;
	logic [CLK_W-1:0] fast_clk_q;
	logic             by8_q;

	logic  chain_valid [NUM_W+1];
	logic  chain_ready [NUM_W+1];
	cell_t chain_data  [NUM_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slow_clk_q <= CLK_RESET;
			fast_clk_q <= CLK_RESET;
			by8_q      <= 1'b0;
		end else if (cfg_en) begin
			case (cfg_index)
				REG_SLOW_CLK: slow_clk_q <= cfg_data;
				REG_FAST_CLK: fast_clk_q <= cfg_data;
				REG_OVER8:    by8_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	ubdc_prep u_prep (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.baud_rate      (baud_rate),
		.use_fast_clock (use_fast_clock),
		.slow_clk_hz    (slow_clk_q),
		.fast_clk_hz    (fast_clk_q),
		.by8            (by8_q),
		.dn_valid       (chain_valid[0]),
		.dn_ready       (chain_ready[0]),
		.dn_data        (chain_data[0])
	);

	for (genvar i = 0; i < NUM_W; i++) begin : g_cell
		ubdc_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (chain_valid[i]),
			.up_ready (chain_ready[i]),
			.up_data  (chain_data[i]),
			.dn_valid (chain_valid[i+1]),
			.dn_ready (chain_ready[i+1]),
			.dn_data  (chain_data[i+1])
		);
	end

	ubdc_finish u_finish (
		.clk          (clk),
		.arst_n       (arst_n),
		.up_valid     (chain_valid[NUM_W]),
		.up_ready     (chain_ready[NUM_W]),
		.up_data      (chain_data[NUM_W]),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.mantissa     (mantissa),
		.fraction     (fraction),
		.divisor_word (divisor_word),
		.status       (status)
	);

endmodule

>>> hdl/ubdc_prep.sv
// Input stage: selects the clock, forms 25 times the clock and the scaled divisor.
module ubdc_prep
	import ubdc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BAUD_W-1:0] baud_rate,
	input  logic              use_fast_clock,
	input  logic [CLK_W-1:0]  slow_clk_hz,
	input  logic [CLK_W-1:0]  fast_clk_hz,
	input  logic              by8,
	output logic              dn_valid,
	input  logic              dn_ready,
	output cell_t             dn_data
);

	logic [CLK_W-1:0] sel_clk;
	logic [NUM_W-1:0] num;
	logic [DVSR_W-1:0] dvsr;
	logic             valid_q;
	cell_t            data_q;

	assign sel_clk = use_fast_clock ? fast_clk_hz : slow_clk_hz;
	assign num = {sel_clk, 4'b0000} + {1'b0, sel_clk, 3'b000} + NUM_W'(sel_clk);
	assign dvsr = by8 ? {1'b0, baud_rate, 1'b0} : {baud_rate, 2'b00};

	assign in_ready = ~valid_q | dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q.rem  <= '0;
			data_q.dq   <= num;
			data_q.dvsr <= dvsr;
			data_q.zero <= (baud_rate == '0);
			data_q.by8  <= by8;
		end
	end

	assign dn_valid = valid_q;
	assign dn_data  = data_q;

endmodule

>>> hdl/ubdc_div_cell.sv
// One restoring-division cell that produces one quotient bit per item.
module ubdc_div_cell
	import ubdc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  up_valid,
	output logic  up_ready,
	input  cell_t up_data,
	output logic  dn_valid,
	input  logic  dn_ready,
	output cell_t dn_data
);

	logic [DVSR_W:0] shifted;
	logic [DVSR_W:0] trial;
	logic            qbit;
	logic            valid_q;
	cell_t           data_q;

	assign shifted = {up_data.rem, up_data.dq[NUM_W-1]};
	assign trial   = shifted - {1'b0, up_data.dvsr};
	assign qbit    = ~trial[DVSR_W];

	assign up_ready = ~valid_q | dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			data_q.rem  <= qbit ? trial[DVSR_W-1:0] : shifted[DVSR_W-1:0];
			data_q.dq   <= {up_data.dq[NUM_W-2:0], qbit};
			data_q.dvsr <= up_data.dvsr;
			data_q.zero <= up_data.zero;
			data_q.by8  <= up_data.by8;
		end
	end

	assign dn_valid = valid_q;
	assign dn_data  = data_q;

endmodule

>>> hdl/ubdc_finish.sv
// Output stages: split the divider into mantissa and rounded fraction and pack the word.
module ubdc_finish
	import ubdc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              up_valid,
	output logic              up_ready,
	input  cell_t             up_data,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [MANT_W-1:0] mantissa,
	output logic [FRAC_W-1:0] fraction,
	output logic [WORD_W-1:0] divisor_word,
	output logic [STAT_W-1:0] status
);

	logic [NUM_W-1:0]    quo;
	logic                big;
	logic [38:0]         mprod;
	logic                ready1, ready2, ready3;

	logic                valid_s1;
	logic [MANT_W-1:0]   mant_s1;
	logic [DIVL_W-1:0]   divl_s1;
	logic                big_s1, zero_s1, by8_s1;

	logic [DIVL_W-1:0]   rem_full;
	logic                valid_s2;
	logic [MANT_W-1:0]   mant_s2;
	logic [REM100_W-1:0] rem_s2;
	logic                big_s2, zero_s2, by8_s2;

	logic [10:0]         scaled;
	logic [22:0]         fprod;
	logic [4:0]          fr;
	logic                carry;
	logic [FRAC_W-1:0]   fmask;
	logic [MANT_W:0]     mant_c;
	logic [MANT_W-1:0]   mant_n;
	logic [FRAC_W-1:0]   frac_n;
	logic [STAT_W-1:0]   stat_n;
	logic                valid_s3;
	logic [MANT_W-1:0]   mant_s3;
	logic [FRAC_W-1:0]   frac_s3;
	logic [STAT_W-1:0]   stat_s3;

	assign ready3   = ~valid_s3 | out_ready;
	assign ready2   = ~valid_s2 | ready3;
	assign ready1   = ~valid_s1 | ready2;
	assign up_ready = ready1;

	// Stage 1: range check and mantissa by reciprocal of 100.
	assign quo   = up_data.dq;
	assign big   = (quo[NUM_W-1:DIVL_W] != '0) || (quo[DIVL_W-1:0] >= DIV_LIMIT);
	assign mprod = 39'(quo[DIVL_W-1:0]) * 39'(RECIP100);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready1) begin
				valid_s1 <= up_valid;
			end
			if (ready2) begin
				valid_s2 <= valid_s1;
			end
			if (ready3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && ready1) begin
			mant_s1 <= mprod[37:26];
			divl_s1 <= quo[DIVL_W-1:0];
			big_s1  <= big;
			zero_s1 <= up_data.zero;
			by8_s1  <= up_data.by8;
		end
	end

	// Stage 2: remainder of the divider modulo 100.
	assign rem_full = divl_s1 - DIVL_W'(mant_s1) * HUNDRED;

	always_ff @(posedge clk) begin
		if (valid_s1 && ready2) begin
			mant_s2 <= mant_s1;
			rem_s2  <= rem_full[REM100_W-1:0];
			big_s2  <= big_s1;
			zero_s2 <= zero_s1;
			by8_s2  <= by8_s1;
		end
	end

	// Stage 3: rounded fraction, carry into the mantissa, saturation and status.
	assign scaled = (by8_s2 ? {1'b0, rem_s2, 3'b000} : {rem_s2, 4'b0000}) + ROUND_HALF;
	assign fprod  = 23'(scaled) * 23'(RECIP100_SMALL);
	assign fr     = fprod[22:18];
	assign carry  = by8_s2 ? fr[3] : fr[4];
	assign fmask  = by8_s2 ? FMASK8 : FMASK16;
	assign mant_c = {1'b0, mant_s2} + (MANT_W+1)'(carry);

	always_comb begin
		if (zero_s2) begin
			mant_n = '0;
			frac_n = '0;
			stat_n = STAT_BAUD_ZERO;
		end else if (big_s2 || mant_c[MANT_W]) begin
			mant_n = MANT_MAX;
			frac_n = fmask;
			stat_n = STAT_RANGE;
		end else begin
			mant_n = mant_c[MANT_W-1:0];
			frac_n = fr[FRAC_W-1:0] & fmask;
			stat_n = STAT_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && ready3) begin
			mant_s3 <= mant_n;
			frac_s3 <= frac_n;
			stat_s3 <= stat_n;
		end
	end

	assign out_valid    = valid_s3;
	assign mantissa     = mant_s3;
	assign fraction     = frac_s3;
	assign divisor_word = {mant_s3, frac_s3};
	assign status       = stat_s3;

endmodule
